>>> rtl/far_pkg.sv
// ----------------------------------------------------------------------------
// far_pkg
// Shared types and constants for the fraction arithmetic reduce block.
// ----------------------------------------------------------------------------
package far_pkg;

  localparam int unsigned InW  = 31;
  localparam int unsigned MagW = 62;
  localparam int unsigned NumW = 63;
  localparam int unsigned DenW = 61;
  localparam int unsigned CntW = 6;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;    // capture input operands
    logic mul_start;  // capture num/den for op from the products
    logic gcd_step;   // one Euclid remainder bit step
    logic gcd_swap;   // finish one remainder, swap pair
    logic div_init;   // start dividing num and den by gcd
    logic div_step;   // one quotient bit step
    logic out_load;   // form result into output register
    op_e  op;
  } far_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic special;    // zero den or zero num: no reduction needed
    logic b_zero;     // Euclid finished
  } far_sts_t;

endpackage

>>> rtl/far_ctrl.sv
// ----------------------------------------------------------------------------
// far_ctrl
// Sequencer: for each of four operations it forms num and den from the
// products, runs the Euclid loop with a bit-serial remainder unit, divides
// both terms by the gcd bit-serially and loads the output register.
// ----------------------------------------------------------------------------
module far_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_busy_i,
  input  far_pkg::far_sts_t  sts_i,
  output far_pkg::far_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_CHK  = 8'b0000_0100,
    ST_REM  = 8'b0000_1000,
    ST_SWP  = 8'b0001_0000,
    ST_DIV  = 8'b0010_0000,
    ST_QUO  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [far_pkg::CntW-1:0]    cnt_q, cnt_d;
  far_pkg::op_e                op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      op_q    <= far_pkg::OP_ADD;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_q    <= op_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d    = far_pkg::OP_ADD;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_start = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.special || sts_i.b_zero) begin
          state_d = ST_DIV;
        end else begin
          cnt_d   = '0;
          state_d = ST_REM;
        end
      end
      ST_REM: begin
        cmd_o.gcd_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == far_pkg::CntW'(far_pkg::MagW - 1)) state_d = ST_SWP;
      end
      ST_SWP: begin
        cmd_o.gcd_swap = 1'b1;
        state_d = ST_CHK;
      end
      ST_DIV: begin
        cmd_o.div_init = 1'b1;
        cnt_d   = '0;
        state_d = sts_i.special ? ST_OUT : ST_QUO;
      end
      ST_QUO: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == far_pkg::CntW'(far_pkg::MagW - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy_i) begin
          cmd_o.out_load = 1'b1;
          if (op_q == far_pkg::OP_DIV) begin
            state_d = ST_IDLE;
          end else begin
            op_d    = far_pkg::op_e'(op_q + 2'd1);
            state_d = ST_MUL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/far_dp.sv
// ----------------------------------------------------------------------------
// far_dp
// Datapath: five 31x31 multipliers that register all products when the
// operands are taken, a bit-serial remainder unit for Euclid, a pair of
// bit-serial dividers for the final reduction and the output register.
// ----------------------------------------------------------------------------
module far_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [4*far_pkg::InW-1:0]  in_data_i,
  input  far_pkg::far_cmd_t          cmd_i,
  output far_pkg::far_sts_t          sts_o,
  output logic                       out_busy_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [127:0]               out_data_o,
  output logic [2:0]                 out_user_o,
  output logic                       out_last_o
);

  localparam int unsigned W = far_pkg::MagW;

  logic signed [far_pkg::InW-1:0] an_s, ad_s, bn_s, bd_s;
  logic signed [2*far_pkg::InW-1:0] c1_q, c2_q, dd_q, nn_q, db_q;
  logic signed [far_pkg::NumW-1:0] n_s, d_s;
  logic neg_q, zden_q, znum_q;
  logic [W-1:0] mn_q, md_q;     // magnitudes
  logic [W-1:0] ga_q, gb_q, gr_q, gq_q;  // Euclid a, b, partial rem, dividend shift
  logic [W-1:0] qn_q, qd_q, rn_q, rd_q, sn_q, sd_q;
  logic         ov_q;
  logic [far_pkg::NumW-1:0] rnum;
  logic [far_pkg::DenW-1:0] rden;
  logic [far_pkg::NumW-1:0] n_mag, d_mag;
  logic [W:0] gtry, ntry, dtry;

  // input operand fields
  assign an_s = in_data_i[0*far_pkg::InW +: far_pkg::InW];
  assign ad_s = in_data_i[1*far_pkg::InW +: far_pkg::InW];
  assign bn_s = in_data_i[2*far_pkg::InW +: far_pkg::InW];
  assign bd_s = in_data_i[3*far_pkg::InW +: far_pkg::InW];

  // products registered when the operands are taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      c1_q <= an_s * bd_s;
      c2_q <= bn_s * ad_s;
      dd_q <= ad_s * bd_s;
      nn_q <= an_s * bn_s;
      db_q <= ad_s * bn_s;
    end
  end

  // operation operands
  always_comb begin
    case (cmd_i.op)
      far_pkg::OP_ADD: begin
        n_s = {c1_q[2*far_pkg::InW-1], c1_q} + {c2_q[2*far_pkg::InW-1], c2_q};
        d_s = {dd_q[2*far_pkg::InW-1], dd_q};
      end
      far_pkg::OP_SUB: begin
        n_s = {c1_q[2*far_pkg::InW-1], c1_q} - {c2_q[2*far_pkg::InW-1], c2_q};
        d_s = {dd_q[2*far_pkg::InW-1], dd_q};
      end
      far_pkg::OP_MUL: begin
        n_s = {nn_q[2*far_pkg::InW-1], nn_q};
        d_s = {dd_q[2*far_pkg::InW-1], dd_q};
      end
      default: begin
        n_s = {c1_q[2*far_pkg::InW-1], c1_q};
        d_s = {db_q[2*far_pkg::InW-1], db_q};
      end
    endcase
    n_mag = n_s[far_pkg::NumW-1] ? -n_s : n_s;
    d_mag = d_s[far_pkg::NumW-1] ? -d_s : d_s;
  end

  assign gtry = {gr_q, gq_q[W-1]} - {1'b0, gb_q};
  assign ntry = {rn_q, sn_q[W-1]} - {1'b0, ga_q};
  assign dtry = {rd_q, sd_q[W-1]} - {1'b0, ga_q};

  // Euclid and reduction registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      zden_q <= (d_s == '0);
      znum_q <= (n_s == '0);
      neg_q  <= n_s[far_pkg::NumW-1] ^ d_s[far_pkg::NumW-1];
      mn_q   <= n_mag[W-1:0];
      md_q   <= d_mag[W-1:0];
      ga_q   <= n_mag[W-1:0];
      gb_q   <= d_mag[W-1:0];
      gr_q   <= '0;
      gq_q   <= n_mag[W-1:0];
    end
    if (cmd_i.gcd_step) begin
      gq_q <= {gq_q[W-2:0], 1'b0};
      gr_q <= gtry[W] ? {gr_q[W-2:0], gq_q[W-1]} : gtry[W-1:0];
    end
    if (cmd_i.gcd_swap) begin
      ga_q <= gb_q;
      gb_q <= gr_q;
      gq_q <= gb_q;
      gr_q <= '0;
    end
    if (cmd_i.div_init) begin
      rn_q <= '0;
      rd_q <= '0;
      sn_q <= mn_q;
      sd_q <= md_q;
      qn_q <= '0;
      qd_q <= '0;
    end
    if (cmd_i.div_step) begin
      sn_q <= {sn_q[W-2:0], 1'b0};
      sd_q <= {sd_q[W-2:0], 1'b0};
      rn_q <= ntry[W] ? {rn_q[W-2:0], sn_q[W-1]} : ntry[W-1:0];
      rd_q <= dtry[W] ? {rd_q[W-2:0], sd_q[W-1]} : dtry[W-1:0];
      qn_q <= {qn_q[W-2:0], ~ntry[W]};
      qd_q <= {qd_q[W-2:0], ~dtry[W]};
    end
  end

  assign sts_o.special = zden_q | znum_q;
  assign sts_o.b_zero  = (gb_q == '0);

  // result formatting
  always_comb begin
    if (zden_q) begin
      rnum = '0;
      rden = '0;
    end else if (znum_q) begin
      rnum = '0;
      rden = far_pkg::DenW'(1);
    end else begin
      rnum = neg_q ? -{1'b0, qn_q} : {1'b0, qn_q};
      rden = qd_q[far_pkg::DenW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o <= {4'b0, rden, rnum};
      out_user_o <= {zden_q, cmd_i.op};
      out_last_o <= (cmd_i.op == far_pkg::OP_DIV);
    end
  end

  assign out_valid_o = ov_q;
  assign out_busy_o  = ov_q & ~out_ready_i;

endmodule

>>> rtl/fraction_arith_reduce.sv
// ----------------------------------------------------------------------------
// fraction_arith_reduce
// Exact add, subtract, multiply and divide of two fractions, each result
// reduced by its gcd with the sign on the numerator.
// ----------------------------------------------------------------------------
// Each result takes longer the more Euclid remainders it needs; the remainder
// loop and the division are skipped when the result is undefined or zero. A
// held output stalls it. Throughput: one item at a time; the next is taken in
// the cycle after the fourth result is loaded. Reset: asynchronous active low;
// clears the sequencer and output valid.
module fraction_arith_reduce (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // a_num, a_den, b_num, b_den (31 each)
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // res_num 63, res_den 61
  output logic [2:0]   m_axis_tuser,   // op_kind 2, status 1
  output logic         m_axis_tlast
);

  far_pkg::far_cmd_t cmd;
  far_pkg::far_sts_t sts;
  logic              out_busy;

  far_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (out_busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  far_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata[4*far_pkg::InW-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_busy_o  (out_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> tb/far_checker.sv
// ----------------------------------------------------------------------------
// far_checker
// Watches both stream channels of fraction_arith_reduce. It computes the four
// reduced results of every accepted operand transfer and compares each output
// transfer, field by field, against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module far_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           fail_cnt_o,
  output int           pending_o,
  output int           checked_o
);

  typedef struct packed {
    far_pkg::op_e                op;
    logic                        status;
    logic [far_pkg::NumW-1:0]    num;
    logic [far_pkg::DenW-1:0]    den;
    logic                        last;
  } frac_res_t;

  frac_res_t reduced_q[$];
  int        exp_cnt;
  int        got_cnt;

  // Euclid on magnitudes
  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Reduce n/d, sign on the numerator; zero denominator is undefined
  function automatic frac_res_t reduce_frac(far_pkg::op_e op, longint n, longint d);
    frac_res_t       res;
    longint unsigned mn, md, g;
    logic            neg;
    res = '0;
    res.op   = op;
    res.last = (op == far_pkg::OP_DIV);
    if (d == 0) begin
      res.status = 1'b1;
    end else if (n == 0) begin
      res.den = far_pkg::DenW'(1);
    end else begin
      mn  = (n < 0) ? -n : n;
      md  = (d < 0) ? -d : d;
      neg = (n < 0) != (d < 0);
      g   = euclid_gcd(mn, md);
      mn  = mn / g;
      md  = md / g;
      res.num = neg ? far_pkg::NumW'(-mn) : far_pkg::NumW'(mn);
      res.den = far_pkg::DenW'(md);
    end
    return res;
  endfunction

  // Operand transfers: queue sum, difference, product, quotient
  always @(posedge clk_i) begin
    longint an, ad, bn, bd, c1, c2, dd;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      an = $signed(s_axis_tdata[30:0]);
      ad = $signed(s_axis_tdata[61:31]);
      bn = $signed(s_axis_tdata[92:62]);
      bd = $signed(s_axis_tdata[123:93]);
      c1 = an * bd;
      c2 = bn * ad;
      dd = ad * bd;
      reduced_q.push_back(reduce_frac(far_pkg::OP_ADD, c1 + c2, dd));
      reduced_q.push_back(reduce_frac(far_pkg::OP_SUB, c1 - c2, dd));
      reduced_q.push_back(reduce_frac(far_pkg::OP_MUL, an * bn, dd));
      reduced_q.push_back(reduce_frac(far_pkg::OP_DIV, c1, ad * bn));
      exp_cnt = exp_cnt + 4;
    end
  end

  // Result transfers against the oldest expectation
  always @(posedge clk_i) begin
    frac_res_t exp_r;
    int        errs;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      errs = 0;
      if (reduced_q.size() == 0) begin
        $display("%0t: unexpected result transfer, tdata=%h", $time, m_axis_tdata);
        errs = errs + 1;
      end else begin
        exp_r   = reduced_q.pop_front();
        got_cnt = got_cnt + 1;
        if (m_axis_tuser[1:0] != exp_r.op) begin
          $display("%0t: op_kind expected %0d actual %0d", $time, exp_r.op,
                   m_axis_tuser[1:0]);
          errs = errs + 1;
        end
        if (m_axis_tuser[2] != exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   m_axis_tuser[2]);
          errs = errs + 1;
        end
        if (m_axis_tdata[62:0] != exp_r.num) begin
          $display("%0t: res_num expected %0d actual %0d", $time,
                   $signed(exp_r.num), $signed(m_axis_tdata[62:0]));
          errs = errs + 1;
        end
        if (m_axis_tdata[123:63] != exp_r.den) begin
          $display("%0t: res_den expected %0d actual %0d", $time, exp_r.den,
                   m_axis_tdata[123:63]);
          errs = errs + 1;
        end
        if (m_axis_tlast != exp_r.last) begin
          $display("%0t: tlast expected %0b actual %0b", $time, exp_r.last,
                   m_axis_tlast);
          errs = errs + 1;
        end
      end
      checked_o  <= checked_o + 1;
      fail_cnt_o <= fail_cnt_o + errs;
    end
  end

  initial begin
    fail_cnt_o = 0;
    checked_o  = 0;
    exp_cnt    = 0;
    got_cnt    = 0;
  end

  assign pending_o = exp_cnt - got_cnt;

endmodule

>>> tb/tb_fraction_arith_reduce.sv
// ----------------------------------------------------------------------------
// tb_fraction_arith_reduce
// Drives operand pairs into fraction_arith_reduce: directed corner cases
// first, then random fractions of mixed magnitude, with random gaps on both
// channels, one long output hold-off and one drain pause. far_checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fraction_arith_reduce;

  localparam int NumRandom = 290;
  localparam logic [30:0] FMin = 31'h4000_0000;
  localparam logic [30:0] FMax = 31'h3fff_ffff;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  int           fail_cnt;
  int           pending;
  int           checked;
  int           sent_cnt;
  bit           hold_req;
  bit           calm;

  fraction_arith_reduce dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  far_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly small values so reductions are common; full range and extremes too
  function automatic logic [30:0] pick_field();
    case ($urandom_range(0, 9))
      0, 1, 2: return 31'($urandom);
      3, 4, 5, 6: return 31'($signed($urandom_range(0, 48)) - 24);
      7: return ($urandom_range(0, 1)) ? FMin : FMax;
      8: return 31'($urandom_range(0, 1) ? 1 : -1);
      default: return 31'($signed($urandom_range(0, 4000)) * 360360 / 1000);
    endcase
  endfunction

  // One operand transfer; optional random gap afterwards
  task automatic send_pair(logic [30:0] an, logic [30:0] ad, logic [30:0] bn,
                           logic [30:0] bd);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, bd, bn, ad, an};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
    if (!calm && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Output side: random backpressure, a quiet window and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (4000) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  initial begin
    #500_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sent_cnt      = 0;
    hold_req      = 1'b0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: extremes, zero denominators, zero numerators, integers
    send_pair(31'd1, 31'd2, 31'd1, 31'd3);
    send_pair(31'd1, 31'd2, 31'd1, 31'd2);
    send_pair(FMax, FMax, FMax, FMax);
    send_pair(FMin, FMin, FMin, FMin);
    send_pair(FMin, FMax, FMax, FMin);
    send_pair(FMax, 31'd1, FMin, 31'h7fff_ffff);
    send_pair(31'd3, 31'd0, 31'd5, 31'd7);
    send_pair(31'd0, 31'd0, 31'd0, 31'd0);
    send_pair(31'd4, 31'd6, 31'd0, 31'd5);
    send_pair(31'd0, 31'd5, 31'd0, 31'd9);
    send_pair(31'd6, 31'd3, 31'd8, 31'd4);
    send_pair(-31'sd7, 31'd14, 31'd3, -31'sd6);
    send_pair(-31'sd1, -31'sd1, -31'sd1, -31'sd1);
    send_pair(31'd1, 31'd2, -31'sd1, 31'd2);
    send_pair(31'h7fff_ffff, 31'h5555_5555, 31'h2aaa_aaaa, 31'h0000_0001);
    send_pair(31'd832040, 31'd514229, 31'd317811, 31'd196418);
    send_pair(FMin, 31'd2, 31'd1, 31'd0);
    send_pair(31'd0, 31'd3, 31'd0, 31'd0);

    // Random part
    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 150 && i < 200);
      if (i == 60) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
      end
      if (i == 100) hold_req = 1'b1;
      send_pair(pick_field(), pick_field(), pick_field(), pick_field());
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    wait (pending == 0);
    repeat (200) @(posedge clk_i);

    $display("Sent %0d operand pairs (corners, zero denominators, extremes, random);",
             sent_cnt);
    $display("checked %0d reduced results under random backpressure and gaps.", checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
